@@ hdl/itp_pkg.sv @@
// Shared types, character codes and classification functions for the infix to postfix converter.
package itp_pkg;

	localparam logic [7:0] CH_CARET = 8'h5E;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_STAR = 8'h2A;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_PLUS = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_OPEN = 8'h28;
	localparam logic [7:0] CH_CLOSE = 8'h29;
	localparam logic [7:0] CH_SPACE = 8'h20;

	localparam logic [1:0] ST_SYMBOL = 2'd0;
	localparam logic [1:0] ST_OVERFLOW = 2'd1;
	localparam logic [1:0] ST_UNMATCHED = 2'd2;
	localparam logic [1:0] ST_END = 2'd3;

	typedef enum logic [1:0] {
		S_IDLE,
		S_WAIT,
		S_EVAL,
		S_FIN
	} state_t;

	typedef enum logic [1:0] {
		SRC_TOP,
		SRC_SYM,
		SRC_ZERO
	} src_t;

	typedef struct packed {
		logic       load;
		logic       emit;
		src_t       src;
		logic [1:0] emit_status;
		logic       pop;
		logic       push;
		logic       finish;
	} cmd_t;

	typedef struct packed {
		logic kind;
		logic is_space;
		logic is_alnum;
		logic is_open;
		logic is_close;
		logic cnt_zero;
		logic full;
		logic top_is_open;
		logic top_pops;
		logic out_free;
	} dp_status_t;

	// Priority shifted up by one so it fits in two unsigned bits: -1 maps to 0.
	function automatic logic [1:0] prio_f(input logic [7:0] c);
		logic [1:0] p;
		p = 2'd0;
		if (c == CH_CARET || c == CH_DOLLAR) begin
			p = 2'd3;
		end else if (c == CH_STAR || c == CH_SLASH) begin
			p = 2'd2;
		end else if (c == CH_PLUS || c == CH_MINUS) begin
			p = 2'd1;
		end
		return p;
	endfunction

	function automatic logic is_alnum_f(input logic [7:0] c);
		return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
			(c >= 8'h61 && c <= 8'h7A);
	endfunction

endpackage

@@ hdl/itp_ram.sv @@
// Generic single write port RAM with one registered read port.
module itp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ hdl/itp_ctrl.sv @@
// Controller state machine that sequences the operator stack work for each character.
module itp_ctrl
	import itp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  dp_status_t st,
	output cmd_t       cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		cmd.src = SRC_ZERO;
		cmd.emit_status = ST_SYMBOL;
		in_stall = 1'b1;
		case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = S_WAIT;
				end
			end
			S_WAIT: begin
				// The stack top is read back through the registered RAM port here.
				state_d = S_EVAL;
			end
			S_EVAL: begin
				if (st.out_free) begin
					state_d = S_FIN;
					if (st.kind) begin
						cmd.emit = 1'b1;
						if (!st.cnt_zero) begin
							cmd.src = SRC_TOP;
							cmd.pop = 1'b1;
							state_d = S_WAIT;
						end else begin
							cmd.emit_status = ST_END;
						end
					end else if (st.is_space) begin
						state_d = S_FIN;
					end else if (st.is_alnum) begin
						cmd.emit = 1'b1;
						cmd.src = SRC_SYM;
					end else if (st.is_close) begin
						if (st.cnt_zero) begin
							cmd.emit = 1'b1;
							cmd.emit_status = ST_UNMATCHED;
						end else if (st.top_is_open) begin
							cmd.pop = 1'b1;
						end else begin
							cmd.emit = 1'b1;
							cmd.src = SRC_TOP;
							cmd.pop = 1'b1;
							state_d = S_WAIT;
						end
					end else if (!st.is_open && st.top_pops) begin
						cmd.emit = 1'b1;
						cmd.src = SRC_TOP;
						cmd.pop = 1'b1;
						state_d = S_WAIT;
					end else if (st.full) begin
						cmd.emit = 1'b1;
						cmd.emit_status = ST_OVERFLOW;
					end else begin
						cmd.push = 1'b1;
					end
				end
			end
			S_FIN: begin
				if (st.out_free) begin
					cmd.finish = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

@@ hdl/itp_datapath.sv @@
// Datapath with the operator stack, the held result and the output register.
module itp_datapath
	import itp_pkg::*;
#(
	parameter int STACK_DEPTH = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       kind,
	input  logic [7:0] symbol,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_symbol,
	output logic [1:0] status,
	output logic       last,
	input  cmd_t       cmd,
	output dp_status_t st
);

	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int AW = $clog2(STACK_DEPTH);

	logic          kind_q;
	logic [7:0]    sym_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] cnt_m1;
	logic [7:0]    top;
	logic          hold_valid_q;
	logic [7:0]    hold_sym_q;
	logic [1:0]    hold_status_q;
	logic          out_valid_q;
	logic [7:0]    out_symbol_q;
	logic [1:0]    out_status_q;
	logic          out_last_q;
	logic [7:0]    new_sym;
	logic          move_out;

	assign cnt_m1 = cnt_q - CW'(1);

	itp_ram #(
		.WIDTH(8),
		.DEPTH(STACK_DEPTH)
	) u_stack (
		.clk  (clk),
		.we   (cmd.push),
		.waddr(cnt_q[AW-1:0]),
		.wdata(sym_q),
		.raddr(cnt_m1[AW-1:0]),
		.rdata(top)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= kind;
			sym_q <= symbol;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.pop) begin
			cnt_q <= cnt_m1;
		end else if (cmd.push) begin
			cnt_q <= cnt_q + CW'(1);
		end
	end

	always_comb begin
		case (cmd.src)
			SRC_TOP: new_sym = top;
			SRC_SYM: new_sym = sym_q;
			default: new_sym = 8'h00;
		endcase
	end

	// A new result pushes the held one out; finishing the item releases it marked last.
	assign move_out = hold_valid_q && (cmd.emit || cmd.finish);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			hold_valid_q <= 1'b1;
		end else if (cmd.finish) begin
			hold_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			hold_sym_q <= new_sym;
			hold_status_q <= cmd.emit_status;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (move_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move_out) begin
			out_symbol_q <= hold_sym_q;
			out_status_q <= hold_status_q;
			out_last_q <= cmd.finish;
		end
	end

	assign out_valid = out_valid_q;
	assign out_symbol = out_symbol_q;
	assign status = out_status_q;
	assign last = out_last_q;

	always_comb begin
		st.kind = kind_q;
		st.is_space = (sym_q == CH_SPACE);
		st.is_alnum = is_alnum_f(sym_q);
		st.is_open = (sym_q == CH_OPEN);
		st.is_close = (sym_q == CH_CLOSE);
		st.cnt_zero = (cnt_q == '0);
		st.full = (cnt_q >= CW'(STACK_DEPTH));
		st.top_is_open = (top == CH_OPEN);
		st.top_pops = !st.cnt_zero && !st.top_is_open && (prio_f(top) >= prio_f(sym_q));
		st.out_free = !out_valid_q || !out_stall;
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(STACK_DEPTH))
		else $error("stack count above depth");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |-> cnt_q != '0)
		else $error("pop from empty stack");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> cnt_q < CW'(STACK_DEPTH))
		else $error("push onto full stack");

	a_out_not_lost: assert property (@(posedge clk) disable iff (!arst_n)
		move_out |-> (!out_valid_q || !out_stall))
		else $error("result overwrites a stalled output");

endmodule

@@ hdl/infix_to_postfix_converter.sv @@
// Top level of the shunting-yard infix to postfix converter.
//
// Input channel: in_valid, in_stall, kind, symbol. A transaction moves one
// expression character (kind 0) or an end-of-expression mark (kind 1).
// Output channel: out_valid, out_stall, out_symbol, status, last. A
// transaction moves one postfix character or one status item; last marks
// the final result caused by an input transaction. An input that produces
// no result (a space, a push, a matched close paren with nothing between)
// gives no output transaction.
// One transaction is worked on at a time. An input passes through the wait,
// evaluate and finish states, and each operator popped off the stack takes
// another pass through the wait and evaluate states; the pop rate is set by
// the registered read port of the stack RAM, whose new top is read back in
// the wait state. The last result of an input leaves the hold register when the input finishes.
// Results leave through a one-entry hold register and an output register,
// so a new result can be formed while the one before it is being taken from
// the output register. When the receiver stalls, the
// controller waits before it forms another result; nothing is dropped.
// Reset (arst_n low) empties the stack and clears the output valid; stack
// contents are not cleared and need no clearing pass.
module infix_to_postfix_converter
	import itp_pkg::*;
#(
	parameter int STACK_DEPTH = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       kind,
	input  logic [7:0] symbol,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_symbol,
	output logic [1:0] status,
	output logic       last
);

	// Commands flow from the controller to the datapath, status flows back.
	cmd_t       cmd;
	dp_status_t st;

	itp_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.st      (st),
		.cmd     (cmd)
	);

	itp_datapath #(
		.STACK_DEPTH(STACK_DEPTH)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.kind      (kind),
		.symbol    (symbol),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_symbol(out_symbol),
		.status    (status),
		.last      (last),
		.cmd       (cmd),
		.st        (st)
	);

endmodule
